FILE: rtl/pfla_pkg.sv
// Shared types and constants for the page free-list allocator.
package pfla_pkg;

   localparam int ACTION_W   = 2;
   localparam int PAGE_NUM_W = 11;
   localparam int RESULT_W   = 10;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC    = 2'd0,
      ACT_DISPOSE  = 2'd1,
      ACT_GET_THIS = 2'd2,
      ACT_GET_NEXT = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic                status;
      logic [RESULT_W-1:0] page;
   } rsp_type;

endpackage

FILE: rtl/pfla_link_ram.sv
// Page link memory with one write port and one registered read port.
module pfla_link_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] link_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= link_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pfla_ctrl.sv
// Operation sequencer: free-list head, page count and link memory updates.
module pfla_ctrl #(
   parameter int MAX_PAGES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pfla_pkg::action_type                 req_action,
   input  logic [pfla_pkg::PAGE_NUM_W-1:0]      req_page,
   input  logic                                 csr_valid,
   input  logic                                 csr_data,
   output logic [$clog2(MAX_PAGES)-1:0]         rd_addr,
   input  logic [$clog2(MAX_PAGES+2)-1:0]       rd_data,
   output logic                                 wr_en,
   output logic [$clog2(MAX_PAGES)-1:0]         wr_addr,
   output logic [$clog2(MAX_PAGES+2)-1:0]       wr_data,
   input  logic                                 slot_free,
   output logic                                 push,
   output pfla_pkg::rsp_type                    push_data
);

   localparam int PW  = $clog2(MAX_PAGES);
   localparam int CW  = $clog2(MAX_PAGES + 1);
   localparam int LW  = $clog2(MAX_PAGES + 2);
   localparam int PNW = pfla_pkg::PAGE_NUM_W;
   localparam int RW  = pfla_pkg::RESULT_W;
   localparam int IPW = (CW > PNW) ? CW : PNW;
   localparam logic [LW-1:0] LINK_USED = LW'(MAX_PAGES);
   localparam logic [LW-1:0] LINK_END  = LW'(MAX_PAGES + 1);

   pfla_pkg::state_type  state_ff, state_in;
   pfla_pkg::action_type action_ff, action_in;
   logic                 file_open_ff, file_open_in;
   logic [LW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [PNW-1:0]       pn_ff, pn_in;
   logic [PW-1:0]        addr_ff, addr_in;
   logic [IPW-1:0]       issue_ff, issue_in;
   logic [PW-1:0]        chk_ff, chk_in;
   logic                 dvalid_ff, dvalid_in;

   logic [IPW-1:0] req_pn_ext;
   logic [IPW-1:0] pn_ext;
   logic [IPW-1:0] count_ext;
   logic           in_range;
   logic           head_valid;
   logic           count_full;
   logic           more;
   logic           used;
   logic           hit;

   assign req_pn_ext = IPW'(req_page[PNW-2:0]);
   assign pn_ext     = IPW'(pn_ff[PNW-2:0]);
   assign count_ext  = IPW'(count_ff);
   assign in_range   = !pn_ff[PNW-1] && (pn_ext < count_ext);
   assign head_valid = head_ff < LINK_USED;
   assign count_full = count_ff >= CW'(MAX_PAGES);
   assign more       = issue_ff < count_ext;
   assign used       = rd_data == LINK_USED;
   assign hit        = dvalid_ff && used;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfla_pkg::ST_IDLE;
         file_open_ff <= 1'b0;
         head_ff      <= LINK_END;
         count_ff     <= '0;
         dvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         file_open_ff <= file_open_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         dvalid_ff    <= dvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      pn_ff     <= pn_in;
      addr_ff   <= addr_in;
      issue_ff  <= issue_in;
      chk_ff    <= chk_in;
   end

   always_comb begin
      state_in     = state_ff;
      file_open_in = csr_valid ? csr_data : file_open_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      action_in    = action_ff;
      pn_in        = pn_ff;
      addr_in      = addr_ff;
      issue_in     = issue_ff;
      chk_in       = chk_ff;
      dvalid_in    = dvalid_ff;
      req_ready    = 1'b0;
      rd_addr      = addr_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = LINK_USED;
      push         = 1'b0;
      push_data    = '{status: pfla_pkg::STATUS_ERR, page: '0};

      case (state_ff)
         pfla_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_action == pfla_pkg::ACT_ALLOC) begin
               rd_addr = head_ff[PW-1:0];
            end else begin
               rd_addr = req_pn_ext[PW-1:0];
            end
            if (req_valid) begin
               action_in = req_action;
               pn_in     = req_page;
               addr_in   = rd_addr;
               issue_in  = req_page[PNW-1] ? '0 : req_pn_ext + IPW'(1);
               dvalid_in = 1'b0;
               if (req_action == pfla_pkg::ACT_GET_NEXT && file_open_ff) begin
                  state_in = pfla_pkg::ST_SCAN;
               end else begin
                  state_in = pfla_pkg::ST_EXEC;
               end
            end
         end

         pfla_pkg::ST_EXEC: begin
            if (slot_free) begin
               push     = 1'b1;
               state_in = pfla_pkg::ST_IDLE;
               if (file_open_ff) begin
                  case (action_ff)
                     pfla_pkg::ACT_ALLOC: begin
                        if (head_valid) begin
                           head_in   = rd_data;
                           wr_en     = 1'b1;
                           push_data = '{status: pfla_pkg::STATUS_OK, page: RW'(addr_ff)};
                        end else if (!count_full) begin
                           count_in  = count_ff + CW'(1);
                           wr_en     = 1'b1;
                           wr_addr   = count_ff[PW-1:0];
                           push_data = '{status: pfla_pkg::STATUS_OK,
                                         page: RW'(count_ff[PW-1:0])};
                        end
                     end
                     pfla_pkg::ACT_DISPOSE: begin
                        if (in_range && used) begin
                           wr_en     = 1'b1;
                           wr_data   = head_ff;
                           head_in   = LW'(addr_ff);
                           push_data = '{status: pfla_pkg::STATUS_OK, page: RW'(addr_ff)};
                        end
                     end
                     pfla_pkg::ACT_GET_THIS: begin
                        if (in_range && used) begin
                           push_data = '{status: pfla_pkg::STATUS_OK, page: RW'(addr_ff)};
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         pfla_pkg::ST_SCAN: begin
            rd_addr = issue_ff[PW-1:0];
            if (hit) begin
               rd_addr = chk_ff;
               if (slot_free) begin
                  push      = 1'b1;
                  push_data = '{status: pfla_pkg::STATUS_OK, page: RW'(chk_ff)};
                  dvalid_in = 1'b0;
                  state_in  = pfla_pkg::ST_IDLE;
               end
            end else if (more) begin
               chk_in    = issue_ff[PW-1:0];
               issue_in  = issue_ff + IPW'(1);
               dvalid_in = 1'b1;
            end else if (dvalid_ff) begin
               dvalid_in = 1'b0;
            end else if (slot_free) begin
               push     = 1'b1;
               state_in = pfla_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pfla_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/pfla_rsp_buf.sv
// Result output register between the sequencer and the result channel.
module pfla_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfla_pkg::rsp_type push_data,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pfla_pkg::rsp_type rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   pfla_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/page_free_list_allocator.sv
// Page free-list allocator: hands out and takes back page numbers of one paged file.
// Each request beat yields exactly one response beat. Allocate, dispose and get-this
// read the page link memory in the idle step and check the link in the exec step,
// where allocate and dispose also write it. Get-next reads one link word per cycle,
// unless a found page waits on rsp_tready, from the page after its start page up to
// page_count - 1. A response beat that waits on rsp_tready holds the block in its
// current step until the output frees. The link memory is not cleared after reset
// and the block accepts requests at once. The user must write the file_open register
// on the csr port only while no request is in flight; the block does not enforce it.
module page_free_list_allocator #(
   parameter int MAX_PAGES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [10:0] page_number (signed), rest zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] result_page, rest zero
   output logic [0:0]  rsp_tuser,   // [0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_wdata    // [0] file_open
);

   localparam int PW = $clog2(MAX_PAGES);
   localparam int LW = $clog2(MAX_PAGES + 2);

   logic [PW-1:0]     rd_addr;
   logic [LW-1:0]     rd_data;
   logic              wr_en;
   logic [PW-1:0]     wr_addr;
   logic [LW-1:0]     wr_data;
   logic              slot_free;
   logic              push;
   pfla_pkg::rsp_type push_data;
   pfla_pkg::rsp_type rsp_data;

   assign csr_ready = 1'b1;

   pfla_ctrl #(
      .MAX_PAGES(MAX_PAGES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (pfla_pkg::action_type'(req_tuser)),
      .req_page   (req_tdata[pfla_pkg::PAGE_NUM_W-1:0]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_wdata[0]),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .slot_free  (slot_free),
      .push       (push),
      .push_data  (push_data)
   );

   pfla_link_ram #(
      .DEPTH(MAX_PAGES),
      .WIDTH(LW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfla_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = 16'(rsp_data.page);
   assign rsp_tuser = rsp_data.status;

endmodule
